>>> hdl/vuc_pkg.sv
// Shared types, constants and codes for the vector micro-op cracker.
// No dependencies; used by vuc_count, vuc_uop and vector_uop_cracker_core.
package vuc_pkg;

  // Vector register length in bits and the longest run of micro-ops
  localparam int VLEN_BITS = 128;
  localparam int MAX_UOPS  = 8;

  // Elements per register at SEW 8 is 2**EPU_LOG2_MAX; each SEW step halves it
  localparam int EPU_LOG2_MAX = $clog2(VLEN_BITS / 8);
  localparam int LG_W         = $clog2(EPU_LOG2_MAX + 1);
  // Width of (k+1) * elements-per-register, at least as wide as VL
  localparam int TAIL_W       = (4 + EPU_LOG2_MAX > 8) ? 4 + EPU_LOG2_MAX : 8;
  // Uop count before the limit check: up to twice ceil(255 / 2)
  localparam int CNT_W        = 10;

  // Crack kinds
  typedef enum logic [3:0] {
    CMD_ELEMENTWISE = 4'd0,
    CMD_SINGLE_DEST = 4'd1,
    CMD_SINGLE_SRC  = 4'd2,
    CMD_WIDEN       = 4'd3,
    CMD_WIDEN_MIXED = 4'd4,
    CMD_MAC         = 4'd5,
    CMD_MAC_WIDE    = 4'd6,
    CMD_NARROW      = 4'd7,
    CMD_REDUCE      = 4'd8,
    CMD_REDUCE_WIDE = 4'd9,
    CMD_INT_EXT     = 4'd10,
    CMD_SLIDE1      = 4'd11
  } cmd_t;

  // Source operand kinds; the spare code behaves as scalar
  typedef enum logic [1:0] {
    SRC_ABSENT = 2'd0,
    SRC_VECTOR = 2'd1,
    SRC_SCALAR = 2'd2
  } src_kind_t;

  // Integer extension factor codes
  typedef enum logic [1:0] {
    EXT_BY_2 = 2'd0,
    EXT_BY_4 = 2'd1,
    EXT_BY_8 = 2'd2
  } ext_code_t;

  // Decoded instruction held while its micro-ops are issued
  typedef struct packed {
    logic [3:0]      cmd;
    logic            slide_down;
    logic [4:0]      dest_reg;
    logic [4:0]      first_src_reg;
    logic [1:0]      first_src_kind;
    logic [4:0]      second_src_reg;
    logic [1:0]      second_src_kind;
    logic [7:0]      vector_length;
    logic [LG_W-1:0] epu_lg;
    logic [1:0]      extend_factor_code;
    logic [2:0]      last_k;
    logic            err;
    logic            skip;
  } item_t;

  // One micro-op as it leaves the calculation logic
  typedef struct packed {
    logic [2:0] uop_index;
    logic [4:0] dest_reg;
    logic [4:0] first_src;
    logic       first_src_present;
    logic [4:0] second_src;
    logic       second_src_present;
    logic [4:0] third_src;
    logic       third_src_present;
    logic       has_tail;
    logic       last_uop;
    logic       error;
  } uop_t;

endpackage

>>> hdl/vuc_count.sv
// Request decode: elements per register, micro-op count and limit check.
// Depends on vuc_pkg.
module vuc_count (
  input  logic [3:0]         command,
  input  logic               slide_down,
  input  logic [4:0]         dest_reg,
  input  logic [4:0]         first_src_reg,
  input  logic [1:0]         first_src_kind,
  input  logic [4:0]         second_src_reg,
  input  logic [1:0]         second_src_kind,
  input  logic [7:0]         vector_length,
  input  logic [1:0]         element_width_code,
  input  logic [1:0]         extend_factor_code,
  input  logic [3:0]         whole_register_count,
  output vuc_pkg::item_t     item
);

  logic [vuc_pkg::LG_W-1:0]  lg;
  logic [8:0]                mask_wide;
  logic [7:0]                rem_mask;
  logic [7:0]                quot;
  logic [vuc_pkg::CNT_W-1:0] base;
  logic [vuc_pkg::CNT_W-1:0] cnt;
  logic                      wide;
  logic                      over;

  // log2 of elements per register
  assign lg = vuc_pkg::LG_W'(vuc_pkg::EPU_LOG2_MAX) - vuc_pkg::LG_W'(element_width_code);

  // ceil(VL / epu) as a shift plus a round-up on the remainder
  assign mask_wide = (9'd1 << lg) - 9'd1;
  assign rem_mask  = mask_wide[7:0];
  assign quot      = vector_length >> lg;
  assign base      = vuc_pkg::CNT_W'(quot) + vuc_pkg::CNT_W'(|(vector_length & rem_mask));

  assign wide = (command == vuc_pkg::CMD_WIDEN)       || (command == vuc_pkg::CMD_WIDEN_MIXED) ||
                (command == vuc_pkg::CMD_MAC_WIDE)    || (command == vuc_pkg::CMD_REDUCE_WIDE);

  // Wide kinds double the count; otherwise a whole-register count overrides it
  always_comb begin
    priority if (wide) begin
      cnt = base << 1;
    end else if (whole_register_count != 4'd0) begin
      cnt = vuc_pkg::CNT_W'(whole_register_count);
    end else begin
      cnt = base;
    end
  end

  assign over = cnt > vuc_pkg::CNT_W'(vuc_pkg::MAX_UOPS);

  always_comb begin
    item.cmd                = command;
    item.slide_down         = slide_down;
    item.dest_reg           = dest_reg;
    item.first_src_reg      = first_src_reg;
    item.first_src_kind     = first_src_kind;
    item.second_src_reg     = second_src_reg;
    item.second_src_kind    = second_src_kind;
    item.vector_length      = vector_length;
    item.epu_lg             = lg;
    item.extend_factor_code = extend_factor_code;
    item.err                = over;
    item.skip               = (cnt == '0);
    item.last_k             = over ? 3'd0 : 3'(cnt - vuc_pkg::CNT_W'(1));
  end

endmodule

>>> hdl/vuc_uop.sv
// Register stepping, third source, tail and last flags for micro-op k.
// Depends on vuc_pkg.
module vuc_uop (
  input  vuc_pkg::item_t item,
  input  logic [2:0]     k,
  output vuc_pkg::uop_t  uop
);

  typedef struct packed {
    logic [4:0] regnum;
    logic       present;
  } src_t;

  logic [3:0]                 k4;
  logic [3:0]                 a1;
  logic [3:0]                 a2;
  logic                       s_ok;
  logic                       last;
  logic [4:0]                 dst;
  logic [1:0]                 ext_sh;
  logic [2:0]                 k_ext;
  src_t                       s1;
  src_t                       s2;
  logic [4:0]                 t_reg;
  logic                       t_pres;
  logic                       has_vec;
  logic [4:0]                 slide_base;
  logic [vuc_pkg::TAIL_W-1:0] covered;

  // Vector sources step, scalars pass when allowed, absent ones read as zero
  function automatic src_t put_src(logic [1:0] kind, logic [4:0] regnum, logic [3:0] amt,
                                   logic ok);
    src_t s;
    unique case (kind)
      vuc_pkg::SRC_ABSENT: s = '0;
      vuc_pkg::SRC_VECTOR: begin
        s.regnum  = regnum + 5'(amt);
        s.present = 1'b1;
      end
      default: begin
        s.regnum  = ok ? regnum : 5'd0;
        s.present = ok;
      end
    endcase
    return s;
  endfunction

  assign k4   = {1'b0, k};
  assign last = (k == item.last_k);
  assign dst  = (item.cmd == vuc_pkg::CMD_SINGLE_DEST) ? item.dest_reg
                                                       : item.dest_reg + 5'(k);

  // Extension factor 2, 4 or 8 as a right shift
  assign ext_sh = (item.extend_factor_code == vuc_pkg::EXT_BY_2) ? 2'd1 :
                  (item.extend_factor_code == vuc_pkg::EXT_BY_4) ? 2'd2 : 2'd3;
  assign k_ext  = k >> ext_sh;

  // Source step amounts per crack kind
  always_comb begin
    a1   = k4;
    a2   = k4;
    s_ok = 1'b1;
    unique case (item.cmd)
      vuc_pkg::CMD_SINGLE_SRC: begin
        a1 = 4'd0;
        a2 = 4'd0;
      end
      vuc_pkg::CMD_WIDEN, vuc_pkg::CMD_MAC_WIDE: begin
        a1 = k4 >> 1;
        a2 = k4 >> 1;
      end
      vuc_pkg::CMD_WIDEN_MIXED, vuc_pkg::CMD_REDUCE_WIDE: begin
        a1 = k4 >> 1;
      end
      vuc_pkg::CMD_NARROW: begin
        a2 = k4 << 1;
      end
      vuc_pkg::CMD_INT_EXT: begin
        a1 = {1'b0, k_ext};
        a2 = {1'b0, k_ext};
      end
      vuc_pkg::CMD_SLIDE1: begin
        s_ok = item.slide_down ? last : (k == 3'd0);
      end
      default: begin
      end
    endcase
  end

  assign s1 = put_src(item.first_src_kind, item.first_src_reg, a1, s_ok);
  assign s2 = put_src(item.second_src_kind, item.second_src_reg, a2, s_ok);

  // Slide neighbour follows rs2 when it is a vector, else rs1
  assign has_vec    = (item.second_src_kind == vuc_pkg::SRC_VECTOR) ||
                      (item.first_src_kind == vuc_pkg::SRC_VECTOR);
  assign slide_base = (item.second_src_kind == vuc_pkg::SRC_VECTOR) ? item.second_src_reg
                                                                    : item.first_src_reg;

  // Third source
  always_comb begin
    t_reg  = 5'd0;
    t_pres = 1'b0;
    unique case (item.cmd)
      vuc_pkg::CMD_MAC, vuc_pkg::CMD_MAC_WIDE: begin
        t_reg  = dst;
        t_pres = 1'b1;
      end
      vuc_pkg::CMD_REDUCE, vuc_pkg::CMD_REDUCE_WIDE: begin
        if (k != 3'd0) begin
          t_reg  = dst - 5'd1;
          t_pres = 1'b1;
        end
      end
      vuc_pkg::CMD_NARROW: begin
        if (item.second_src_kind == vuc_pkg::SRC_VECTOR) begin
          t_reg  = item.second_src_reg + 5'({k, 1'b1});
          t_pres = 1'b1;
        end
      end
      vuc_pkg::CMD_SLIDE1: begin
        if (has_vec) begin
          if (!item.slide_down && (k != 3'd0)) begin
            t_reg  = slide_base + 5'(k) - 5'd1;
            t_pres = 1'b1;
          end else if (item.slide_down && !last) begin
            t_reg  = slide_base + 5'(k) + 5'd1;
            t_pres = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Elements covered through this uop, against VL
  assign covered = vuc_pkg::TAIL_W'(k4 + 4'd1) << item.epu_lg;

  // Over-limit instructions give one flagged result, all else zero
  always_comb begin
    if (item.err) begin
      uop          = '0;
      uop.last_uop = 1'b1;
      uop.error    = 1'b1;
    end else begin
      uop.uop_index          = k;
      uop.dest_reg           = dst;
      uop.first_src          = s1.regnum;
      uop.first_src_present  = s1.present;
      uop.second_src         = s2.regnum;
      uop.second_src_present = s2.present;
      uop.third_src          = t_reg;
      uop.third_src_present  = t_pres;
      uop.has_tail           = covered > vuc_pkg::TAIL_W'(item.vector_length);
      uop.last_uop           = last;
      uop.error              = 1'b0;
    end
  end

endmodule

>>> hdl/vector_uop_cracker_core.sv
// Vector micro-op cracker top level: request register, uop sequencer, result register.
// Depends on vuc_pkg, vuc_count and vuc_uop.
//
// One decoded vector instruction arrives per request on the s_axis channel
// (kind and slide direction in tuser, operands in tdata). It leaves as a run
// of micro-ops on the m_axis channel, one per beat, tlast on the final one
// and tuser set on the single result of an instruction that needs more than
// the maximum uop count.
// The first micro-op passes through the request register and then the result
// register on its way out.
// Throughput: the sequencer issues one micro-op per cycle while the receiver
// does not stall; an instruction gives 1 to 8 micro-ops, an over-limit one a
// single flagged result, and one with no micro-ops is taken and dropped.
// The next request is taken in the same cycle as the last micro-op of the
// current one moves into the result register, so runs follow back to back.
// When the receiver stalls, the result register holds its beat and the
// sequencer waits; s_axis_tready drops once the request register is busy.
// Reset empties both registers and clears the uop counter; nothing is lost
// or repeated across a stall.
module vector_uop_cracker_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [4:0] dest_reg, [9:5] first_src_reg, [11:10] first_src_kind,
  // [16:12] second_src_reg, [18:17] second_src_kind, [26:19] vector_length,
  // [28:27] element_width_code, [30:29] extend_factor_code,
  // [34:31] whole_register_count, [39:35] zero
  input  logic [39:0] s_axis_tdata,
  // [3:0] command, [4] slide_down
  input  logic [4:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] uop_index, [7:3] out_dest_reg, [12:8] out_first_src,
  // [13] first_src_present, [18:14] out_second_src, [19] second_src_present,
  // [24:20] out_third_src, [25] third_src_present, [26] has_tail, [31:27] zero
  output logic [31:0] m_axis_tdata,
  // [0] error
  output logic        m_axis_tuser,
  output logic        m_axis_tlast
);

  vuc_pkg::item_t in_item;
  vuc_pkg::item_t item;
  logic           item_valid;
  logic           item_valid_next;
  logic [2:0]     k;
  logic [2:0]     k_next;
  vuc_pkg::uop_t  uop;
  vuc_pkg::uop_t  out_uop;
  logic           out_valid;
  logic           out_free;
  logic           advance;
  logic           finish;
  logic           accept;

  // Decode and count on the way in
  vuc_count u_count (
    .command              (s_axis_tuser[3:0]),
    .slide_down           (s_axis_tuser[4]),
    .dest_reg             (s_axis_tdata[4:0]),
    .first_src_reg        (s_axis_tdata[9:5]),
    .first_src_kind       (s_axis_tdata[11:10]),
    .second_src_reg       (s_axis_tdata[16:12]),
    .second_src_kind      (s_axis_tdata[18:17]),
    .vector_length        (s_axis_tdata[26:19]),
    .element_width_code   (s_axis_tdata[28:27]),
    .extend_factor_code   (s_axis_tdata[30:29]),
    .whole_register_count (s_axis_tdata[34:31]),
    .item                 (in_item)
  );

  // Micro-op fields for the current position
  vuc_uop u_uop (
    .item (item),
    .k    (k),
    .uop  (uop)
  );

  // Handshake control
  assign out_free      = !out_valid || m_axis_tready;
  assign advance       = item_valid && out_free;
  assign finish        = advance && uop.last_uop;
  assign s_axis_tready = !item_valid || finish;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    item_valid_next = item_valid;
    k_next          = k;
    if (finish) begin
      item_valid_next = 1'b0;
      k_next          = 3'd0;
    end else if (advance) begin
      k_next = k + 3'd1;
    end
    if (accept) begin
      item_valid_next = !in_item.skip;
    end
  end

  // Request register and uop counter
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      k          <= 3'd0;
    end else begin
      item_valid <= item_valid_next;
      k          <= k_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= in_item;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_uop <= uop;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'd0, out_uop.has_tail, out_uop.third_src_present, out_uop.third_src,
                          out_uop.second_src_present, out_uop.second_src,
                          out_uop.first_src_present, out_uop.first_src,
                          out_uop.dest_reg, out_uop.uop_index};
  assign m_axis_tuser  = out_uop.error;
  assign m_axis_tlast  = out_uop.last_uop;

`ifndef SYNTHESIS
  // The counter never runs past the final position of the held instruction
  assert property (@(posedge clk) disable iff (rst)
    item_valid |-> (k <= item.last_k))
    else $error("uop counter beyond last position");

  // Finishing a run restarts the counter for the next instruction
  assert property (@(posedge clk) disable iff (rst)
    finish |=> (k == 3'd0))
    else $error("uop counter not restarted after last uop");

  // An over-limit result is always the only, and so the last, beat
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("error result without tlast");

  // A stalled result holds while the request register waits behind it
  assert property (@(posedge clk) disable iff (rst)
    (item_valid && out_valid && !m_axis_tready) |=> (item_valid && $stable(k)))
    else $error("sequencer moved during output stall");
`endif

endmodule
